// ----- sv/bfc_pkg.sv -----
// Package for the frustum box cull block: payload types, plane-unit structs
// and sequencer state codes. Used by bfc_plane_unit and frustum_box_cull.
package bfc_pkg;

  // Q16.16 element and coordinate
  typedef logic signed [31:0] q16_t;
  // plane coefficient: sum or difference of two elements
  typedef logic signed [32:0] coef_t;
  // exact coefficient by coordinate product
  typedef logic signed [64:0] prod_t;
  // Q32.32 dot product accumulator
  typedef logic signed [66:0] acc_t;

  localparam int PLANE_COUNT = 6;
  localparam int CNT_W       = 3;
  localparam int Q_FRAC      = 16;

  typedef logic [CNT_W-1:0] plane_cnt_t;

  // operation codes of an input item
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TEST  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  // one plane issued to the shared unit
  typedef struct packed {
    logic valid;
    logic sub;    // odd plane: row 3 minus side row
  } issue_t;

  // verdict of one plane from the shared unit
  typedef struct packed {
    logic valid;
    logic below;  // farthest corner lies below the plane
  } result_t;

endpackage

// ----- sv/bfc_plane_unit.sv -----
// Shared plane unit: forms one plane's coefficients, picks the farthest
// corner and evaluates its dot product over two stages. Uses bfc_pkg.
module bfc_plane_unit (
  input  logic             clk,
  input  logic             rst,
  input  bfc_pkg::issue_t  issue,
  input  bfc_pkg::q16_t    base [4],
  input  bfc_pkg::q16_t    side [4],
  input  bfc_pkg::q16_t    lo [3],
  input  bfc_pkg::q16_t    hi [3],
  output bfc_pkg::result_t result
);
  import bfc_pkg::*;

  coef_t coef [4];
  q16_t  pick [3];
  prod_t prod_next [3];
  prod_t prod [3];
  coef_t dterm;
  logic  stage_valid;
  acc_t  sum;

  // form coefficients and the farthest corner, multiply per axis
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (issue.sub) begin
        coef[i] = coef_t'(base[i]) - coef_t'(side[i]);
      end else begin
        coef[i] = coef_t'(base[i]) + coef_t'(side[i]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      if (coef[i][32]) begin
        pick[i] = (lo[i] > hi[i]) ? hi[i] : lo[i];
      end else begin
        pick[i] = (lo[i] > hi[i]) ? lo[i] : hi[i];
      end
      prod_next[i] = coef[i] * pick[i];
    end
  end

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= issue.valid;
    end
    for (int i = 0; i < 3; i++) begin
      prod[i] <= prod_next[i];
    end
    dterm <= coef[3];
  end

  // sum stage: w is one, so the constant term is d scaled to Q32.32
  assign sum = acc_t'(prod[0]) + acc_t'(prod[1]) + acc_t'(prod[2])
             + (acc_t'(dterm) <<< Q_FRAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else begin
      result.valid <= stage_valid;
    end
    result.below <= sum[66];
  end

endmodule

// ----- sv/frustum_box_cull.sv -----
// Frustum culling of axis-aligned boxes against six planes of a 4x4 matrix.
// Matrix write: no result. Box test: six planes issued one per cycle into the
// two-stage shared plane unit (bfc_plane_unit); no new item is taken until the
// last verdict has loaded the output register. A result still waiting in the
// output register holds the block until it drains.
// Synchronous reset clears the matrix to zero and empties the output. Uses bfc_pkg.
module frustum_box_cull (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic         operation,
  input  logic [1:0]   column,
  input  logic [1:0]   row,
  input  bfc_pkg::q16_t element,
  input  bfc_pkg::q16_t min_x,
  input  bfc_pkg::q16_t min_y,
  input  bfc_pkg::q16_t min_z,
  input  bfc_pkg::q16_t max_x,
  input  bfc_pkg::q16_t max_y,
  input  bfc_pkg::q16_t max_z,
  output logic         out_valid,
  input  logic         out_ready,
  output logic         in_frustum
);
  import bfc_pkg::*;

  state_t     state;
  q16_t       mat [16];
  q16_t       work0 [4];
  q16_t       work1 [4];
  q16_t       work2 [4];
  q16_t       base [4];
  q16_t       lo [3];
  q16_t       hi [3];
  plane_cnt_t issue_cnt;
  plane_cnt_t res_cnt;
  logic       culled;
  logic       culled_next;
  logic       in_xfer;
  logic       out_free;
  logic       out_load;
  logic       last_res;
  issue_t     issue;
  result_t    result;

  assign in_ready = (state == ST_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // row 3 of each column is read at a fixed place
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      base[i] = mat[i*4 + 3];
    end
  end

  // issue one plane a cycle while the count runs
  assign issue = '{valid: (state == ST_RUN) && (issue_cnt < CNT_W'(PLANE_COUNT)),
                   sub:   issue_cnt[0]};

  assign last_res    = result.valid && (res_cnt == CNT_W'(PLANE_COUNT - 1));
  assign culled_next = culled || (result.valid && result.below);

  // load the output register when the last verdict lands or the hold ends
  assign out_load = out_free && (((state == ST_RUN) && last_res) || (state == ST_HOLD));

  bfc_plane_unit u_plane (
    .clk    (clk),
    .rst    (rst),
    .issue  (issue),
    .base   (base),
    .side   (work0),
    .lo     (lo),
    .hi     (hi),
    .result (result)
  );

  // matrix store: reset to zero, written by element transfers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        mat[i] <= '0;
      end
    end else if (in_xfer && operation == OP_WRITE) begin
      mat[{column, row}] <= element;
    end
  end

  // latch the box and a working copy of rows 0..2; advance rows every two planes
  always_ff @(posedge clk) begin
    if (in_xfer && operation == OP_TEST) begin
      lo[0] <= min_x;
      lo[1] <= min_y;
      lo[2] <= min_z;
      hi[0] <= max_x;
      hi[1] <= max_y;
      hi[2] <= max_z;
      for (int i = 0; i < 4; i++) begin
        work0[i] <= mat[i*4];
        work1[i] <= mat[i*4 + 1];
        work2[i] <= mat[i*4 + 2];
      end
    end else if (issue.valid && issue_cnt[0]) begin
      for (int i = 0; i < 4; i++) begin
        work0[i] <= work1[i];
        work1[i] <= work2[i];
      end
    end
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      issue_cnt <= '0;
      res_cnt   <= '0;
      culled    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_xfer && operation == OP_TEST) begin
            state     <= ST_RUN;
            issue_cnt <= '0;
            res_cnt   <= '0;
            culled    <= 1'b0;
          end
        end
        ST_RUN: begin
          if (issue.valid) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (result.valid) begin
            res_cnt <= res_cnt + 1'b1;
            culled  <= culled_next;
          end
          if (last_res) begin
            if (out_free) begin
              in_frustum <= !culled_next;
              state      <= ST_IDLE;
            end else begin
              state <= ST_HOLD;
            end
          end
        end
        ST_HOLD: begin
          // wait for the output register to drain
          if (out_free) begin
            in_frustum <= !culled;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_hold_needs_full_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_HOLD) |-> out_valid)
    else $error("hold state entered with an empty output register");

  a_test_starts_run: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && operation == OP_TEST) |=> (state == ST_RUN))
    else $error("box test transfer did not start the plane sequence");

  a_write_stays_idle: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && operation == OP_WRITE) |=> (state == ST_IDLE))
    else $error("matrix write left the idle state");

  a_results_in_run: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (state == ST_RUN))
    else $error("plane verdict arrived outside the plane sequence");

  a_results_trail_issue: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (res_cnt <= issue_cnt))
    else $error("more plane verdicts than planes issued");
`endif

endmodule

// ----- tb/sv/frustum_box_cull_checker.sv -----
`timescale 1ns / 1ps
// Checker for frustum_box_cull: tracks matrix writes, predicts each box verdict
// and compares it against the result channel. Depends on bfc_pkg.
module frustum_box_cull_checker (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic          operation,
  input  logic [1:0]    column,
  input  logic [1:0]    row,
  input  bfc_pkg::q16_t element,
  input  bfc_pkg::q16_t min_x,
  input  bfc_pkg::q16_t min_y,
  input  bfc_pkg::q16_t min_z,
  input  bfc_pkg::q16_t max_x,
  input  bfc_pkg::q16_t max_y,
  input  bfc_pkg::q16_t max_z,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic          in_frustum,
  output int            failures,
  output int            outstanding
);
  import bfc_pkg::*;

  typedef struct {
    logic        in_frustum;
    int unsigned test_no;
  } verdict_t;

  // shadow copy of the matrix, index column*4+row
  q16_t        proj_matrix [16];
  verdict_t    pending_verdicts [$];
  int unsigned tests_seen;
  int          fail_count;

  // Box survives unless one plane has its farthest corner strictly below it
  function automatic logic predict_in_frustum(input q16_t lo_x, lo_y, lo_z,
                                              input q16_t hi_x, hi_y, hi_z);
    q16_t  lo [3];
    q16_t  hi [3];
    coef_t cf [4];
    acc_t  dot;
    q16_t  far_c;
    int    side;
    logic  survives;
    lo[0] = lo_x;
    lo[1] = lo_y;
    lo[2] = lo_z;
    hi[0] = hi_x;
    hi[1] = hi_y;
    hi[2] = hi_z;
    survives = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      side = p / 2;
      // even planes add the side row to row 3, odd planes subtract it
      for (int i = 0; i < 4; i++) begin
        cf[i] = (p % 2 == 0) ? proj_matrix[i*4+3] + proj_matrix[i*4+side]
                             : proj_matrix[i*4+3] - proj_matrix[i*4+side];
      end
      // offset term times w = 1.0
      dot = acc_t'(cf[3]) <<< Q_FRAC;
      for (int i = 0; i < 3; i++) begin
        // pick the coordinate giving the larger product on this axis
        if (cf[i] >= 0) far_c = (lo[i] > hi[i]) ? lo[i] : hi[i];
        else far_c = (lo[i] > hi[i]) ? hi[i] : lo[i];
        dot = dot + cf[i] * far_c;
      end
      if (dot < 0) survives = 1'b0;
    end
    return survives;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    if (rst) begin
      foreach (proj_matrix[i]) proj_matrix[i] = '0;
      pending_verdicts.delete();
      tests_seen = 0;
      fail_count = 0;
    end else begin
      // compare a result transfer with the oldest expected verdict
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected result: in_frustum=%0b with no box test pending",
                     in_frustum);
        end else begin
          want = pending_verdicts.pop_front();
          if (in_frustum !== want.in_frustum) begin
            fail_count++;
            if (fail_count <= 10)
              $display("box test %0d: in_frustum expected %0b, got %0b",
                       want.test_no, want.in_frustum, in_frustum);
          end
        end
      end
      // apply an element write or predict the verdict of a box test
      if (in_valid && in_ready) begin
        if (operation == OP_WRITE) begin
          proj_matrix[{column, row}] = element;
        end else begin
          want.in_frustum = predict_in_frustum(min_x, min_y, min_z, max_x, max_y, max_z);
          want.test_no = tests_seen;
          tests_seen++;
          pending_verdicts.push_back(want);
        end
      end
    end
    failures <= fail_count;
    outstanding <= pending_verdicts.size();
  end

endmodule

// ----- tb/sv/frustum_box_cull_test.sv -----
`timescale 1ns / 1ps
// Top of the frustum_box_cull testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Uses bfc_pkg and frustum_box_cull_checker.
module frustum_box_cull_test;
  import bfc_pkg::*;

  localparam int ITEM_TARGET    = 1050;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 40;

  localparam q16_t Q_ONE = 32'sh0001_0000;
  localparam q16_t Q_MIN = 32'sh8000_0000;
  localparam q16_t Q_MAX = 32'sh7fff_ffff;

  typedef enum int {
    SCENE_PERSPECTIVE,
    SCENE_SMALL,
    SCENE_WILD
  } scene_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic       operation = OP_WRITE;
  logic [1:0] column    = '0;
  logic [1:0] row       = '0;
  q16_t       element   = '0;
  q16_t       min_x     = '0;
  q16_t       min_y     = '0;
  q16_t       min_z     = '0;
  q16_t       max_x     = '0;
  q16_t       max_y     = '0;
  q16_t       max_z     = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       in_frustum;
  int         failures;
  int         outstanding;

  int          items_sent  = 0;
  int          burst_left  = 0;
  int          idle_cycles = 0;
  int unsigned stall_cycle = 0;

  frustum_box_cull dut (.*);

  frustum_box_cull_checker chk (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: stall pattern mode follows bits 9:8 of a free-running cycle counter
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    case (stall_cycle[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= $urandom_range(0, 1);
      2'd2: out_ready <= (stall_cycle[4:0] < 5'd6);
      default: out_ready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // watchdog: stop when nothing has moved for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic q16_t in_range(input int lo, input int hi);
    return q16_t'(int'($urandom_range(0, hi - lo)) + lo);
  endfunction

  function automatic q16_t signed_span(input int mag);
    return in_range(-mag, mag);
  endfunction

  // Drive one item, holding it until the transfer; insert sender gaps between bursts
  task automatic send_item(input logic op, input logic [1:0] col, input logic [1:0] rw,
                           input q16_t elem, input q16_t lx, ly, lz, hx, hy, hz);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    operation <= op;
    column    <= col;
    row       <= rw;
    element   <= elem;
    min_x     <= lx;
    min_y     <= ly;
    min_z     <= lz;
    max_x     <= hx;
    max_y     <= hy;
    max_z     <= hz;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // box fields are ignored on a write: fill them with noise
  task automatic write_element(input logic [1:0] col, input logic [1:0] rw, input q16_t val);
    send_item(OP_WRITE, col, rw, val, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  // element fields are ignored on a box test: fill them with noise
  task automatic test_box(input q16_t lx, ly, lz, hx, hy, hz);
    send_item(OP_TEST, $urandom_range(0, 3), $urandom_range(0, 3), $urandom,
              lx, ly, lz, hx, hy, hz);
  endtask

  task automatic run_directed();
    // zero matrix: every dot product is zero, so any box stays in
    test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    // offset of -1 alone culls everything
    write_element(3, 3, -Q_ONE);
    test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    // x coefficient of 1 in every plane: corner at x = 1.0 sits exactly on it
    write_element(0, 3, Q_ONE);
    test_box(0, 0, 0, Q_ONE, 0, 0);
    test_box(0, 0, 0, Q_ONE - 1, 0, 0);
    // minimum above maximum
    test_box(Q_ONE, 0, 0, 0, 0, 0);
    // extreme coefficients, positive and negative, at full width
    write_element(0, 3, Q_MAX);
    write_element(0, 0, Q_MIN);
    write_element(1, 3, Q_MIN);
    write_element(1, 1, Q_MAX);
    write_element(2, 3, Q_MIN);
    write_element(2, 2, Q_MIN);
    write_element(3, 3, Q_MAX);
    write_element(3, 2, Q_MAX);
    test_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX);
    test_box(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
    test_box(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
    test_box(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    test_box(Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN);
  endtask

  // Element value for one matrix slot of a scene
  function automatic q16_t matrix_value(input scene_t kind, input int col, input int rw);
    if (kind == SCENE_WILD) return $urandom;
    if (kind == SCENE_SMALL) return signed_span(2 * Q_ONE);
    // perspective projection, camera looking down -z, with slight tilt
    if (col == rw && col < 2) return in_range(Q_ONE / 2, 3 * Q_ONE);
    if (col == 2 && rw == 2) return -in_range(65600, 68000);
    if (col == 3 && rw == 2) return -in_range(6554, 26214);
    if (col == 2 && rw == 3) return -Q_ONE;
    if (col == 3 && rw < 2) return signed_span(2 * Q_ONE);
    if (col < 2 && rw < 2) return signed_span(Q_ONE / 8);
    return '0;
  endfunction

  // Box matching the scale of a scene, optionally a point or with swapped bounds
  task automatic send_scene_box(input scene_t kind, input logic point, input logic swap);
    q16_t c [3];
    q16_t e [3];
    q16_t lo [3];
    q16_t hi [3];
    q16_t t;
    for (int i = 0; i < 3; i++) begin
      case (kind)
        SCENE_PERSPECTIVE: begin
          c[i] = (i == 2) ? in_range(-120 * Q_ONE, 20 * Q_ONE) : signed_span(40 * Q_ONE);
          e[i] = in_range(0, 8 * Q_ONE);
        end
        SCENE_SMALL: begin
          c[i] = signed_span(16 * Q_ONE);
          e[i] = in_range(0, 4 * Q_ONE);
        end
        default: begin
          c[i] = '0;
          e[i] = '0;
        end
      endcase
      if (point) e[i] = '0;
      lo[i] = c[i] - e[i];
      hi[i] = c[i] + e[i];
      if (kind == SCENE_WILD) begin
        lo[i] = $urandom;
        hi[i] = point ? lo[i] : q16_t'($urandom);
      end
      if (swap && $urandom_range(0, 1)) begin
        t = lo[i];
        lo[i] = hi[i];
        hi[i] = t;
      end
    end
    test_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Load a full matrix in shuffled order, then run a batch of box tests
  task automatic run_scene();
    scene_t kind;
    int     order [16];
    int     pick;
    int     j;
    int     t;
    int     tests;
    pick = $urandom_range(0, 9);
    kind = (pick < 5) ? SCENE_PERSPECTIVE : (pick < 8) ? SCENE_SMALL : SCENE_WILD;
    foreach (order[i]) order[i] = i;
    for (int i = 15; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i])
      write_element(order[i] / 4, order[i] % 4, matrix_value(kind, order[i] / 4, order[i] % 4));
    tests = $urandom_range(12, 28);
    for (int n = 0; n < tests; n++) begin
      pick = $urandom_range(0, 19);
      case (pick)
        0: write_element($urandom_range(0, 3), $urandom_range(0, 3), $urandom);
        1: send_scene_box(SCENE_WILD, 1'b0, 1'b0);
        2: send_scene_box(kind, 1'b0, 1'b1);
        3: send_scene_box(kind, 1'b1, 1'b0);
        default: send_scene_box(kind, 1'b0, 1'b0);
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    while (items_sent < ITEM_TARGET) run_scene();
    in_valid <= 1'b0;
    // let the checker see the last transfer, then drain the results
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/bfc_pkg.sv
sv/bfc_plane_unit.sv
sv/frustum_box_cull.sv
tb/sv/frustum_box_cull_checker.sv
tb/sv/frustum_box_cull_test.sv
